// File: rtl/core/gbad_pkg.sv
// ----------------------------------------------------------------------------
// gbad_pkg
// Shared widths, register codes and queue entry types for the grid box
// average downsampler.
// ----------------------------------------------------------------------------
package gbad_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int CELL_W      = 18;
  localparam int SIDE_REG_W  = 7;
  localparam int BLOCK_REG_W = 5;
  localparam int SCALE_W     = 25;
  localparam int SCALE_FRAC  = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'h100_0000;

  localparam int DEF_MAX_OUT_SIDE = 64;
  localparam int DEF_MAX_BLOCK    = 16;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_OUT_SIDE    = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_RECIP_SCALE = 2'd2
  } reg_idx_t;

  // classified sample, front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CELL_W-1:0]          cell_index;
    logic                       first;
    logic                       done;
    logic                       last;
  } cls_t;

  // finished block mean
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [CELL_W-1:0]          cell_index;
    logic                       last;
  } res_t;

endpackage

// File: rtl/core/gbad_fifo.sv
// ----------------------------------------------------------------------------
// gbad_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module gbad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNTW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNTW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/core/gbad_front.sv
// ----------------------------------------------------------------------------
// gbad_front
// Position tracking: walks the grid in row-major order, tags each sample with
// its slab accumulator, block start/end and output cell.
// ----------------------------------------------------------------------------
module gbad_front #(
  parameter int MAX_OUT_SIDE = gbad_pkg::DEF_MAX_OUT_SIDE,
  parameter int MAX_BLOCK    = gbad_pkg::DEF_MAX_BLOCK
) (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic [$clog2(MAX_OUT_SIDE+1)-1:0]            side,
  input  logic [$clog2(MAX_OUT_SIDE*MAX_OUT_SIDE+1)-1:0] side_sq,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]               blk,
  input  logic accept,
  input  logic signed [gbad_pkg::SAMPLE_W-1:0]         sample,
  output gbad_pkg::cls_t cls,
  output logic [((MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE) : 1)-1:0] idx
);

  localparam int CW = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
  localparam int OW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int IW = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE) : 1;
  localparam int XW = (MAX_OUT_SIDE > 1) ?
                      $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE*MAX_OUT_SIDE) : 1;

  logic [CW-1:0] cell_x, cell_y, cell_z;
  logic [OW-1:0] off_i, off_j, off_k;
  logic [IW-1:0] y_base;    // cell_y * M
  logic [XW-1:0] x_base;    // cell_x * M * M
  logic [CW-1:0] side_last;
  logic [OW-1:0] blk_last;
  logic x_end, y_end, z_end, i_end, j_end, k_end;

  always_comb begin
    side_last = CW'(side - 1'b1);
    blk_last  = OW'(blk - 1'b1);
    x_end = (cell_x == side_last);
    y_end = (cell_y == side_last);
    z_end = (cell_z == side_last);
    i_end = (off_i == blk_last);
    j_end = (off_j == blk_last);
    k_end = (off_k == blk_last);

    idx            = IW'(y_base + cell_z);
    cls.sample     = sample;
    cls.cell_index = gbad_pkg::CELL_W'(x_base + y_base + cell_z);
    cls.first      = (off_i == '0) && (off_j == '0) && (off_k == '0);
    cls.done       = i_end && j_end && k_end;
    cls.last       = x_end && y_end && z_end;
  end

  // z fastest, then y, then x; offsets nest inside their cell coordinate
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cell_x <= '0;
      cell_y <= '0;
      cell_z <= '0;
      off_i  <= '0;
      off_j  <= '0;
      off_k  <= '0;
      y_base <= '0;
      x_base <= '0;
    end else if (accept) begin
      if (k_end) begin
        off_k <= '0;
        if (z_end) begin
          cell_z <= '0;
          if (j_end) begin
            off_j <= '0;
            if (y_end) begin
              cell_y <= '0;
              y_base <= '0;
              if (i_end) begin
                off_i <= '0;
                if (x_end) begin
                  cell_x <= '0;
                  x_base <= '0;
                end else begin
                  cell_x <= CW'(cell_x + 1'b1);
                  x_base <= XW'(x_base + side_sq);
                end
              end else begin
                off_i <= OW'(off_i + 1'b1);
              end
            end else begin
              cell_y <= CW'(cell_y + 1'b1);
              y_base <= IW'(y_base + side);
            end
          end else begin
            off_j <= OW'(off_j + 1'b1);
          end
        end else begin
          cell_z <= CW'(cell_z + 1'b1);
        end
      end else begin
        off_k <= OW'(off_k + 1'b1);
      end
    end
  end

endmodule

// File: rtl/core/gbad_back.sv
// ----------------------------------------------------------------------------
// gbad_back
// Slab accumulation and scaling: read-modify-write of the accumulator memory
// with write forwarding, then a two-stage scale and saturate.
// ----------------------------------------------------------------------------
module gbad_back #(
  parameter int MAX_OUT_SIDE = gbad_pkg::DEF_MAX_OUT_SIDE,
  parameter int MAX_BLOCK    = gbad_pkg::DEF_MAX_BLOCK
) (
  input  logic clk,
  input  logic rst,
  input  logic [gbad_pkg::SCALE_W-1:0] recip_scale,
  input  logic mid_empty,
  input  gbad_pkg::cls_t mid_cls,
  input  logic [((MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE) : 1)-1:0] mid_idx,
  output logic mid_pop,
  input  logic [$clog2(gbad_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic out_push,
  output gbad_pkg::res_t out_res
);

  localparam int IW        = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE) : 1;
  localparam int ACC_DEPTH = MAX_OUT_SIDE * MAX_OUT_SIDE;
  localparam int SUM_W     = gbad_pkg::SAMPLE_W +
                             3 * ((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 0);
  localparam int FRAC      = gbad_pkg::SCALE_FRAC;
  localparam int SW        = gbad_pkg::SCALE_W;
  localparam int HI_W      = SUM_W - FRAC;
  localparam int PH_W      = HI_W + SW + 1;
  localparam int TW        = PH_W + 1;
  localparam logic signed [TW-1:0] POS_LIM = TW'(64'sh7FFF_FFFF);
  localparam logic signed [TW-1:0] NEG_LIM = TW'(-64'sh8000_0000);

  logic signed [SUM_W-1:0] acc_mem [ACC_DEPTH];
  logic signed [SUM_W-1:0] rd_sum;

  // stage 1: accumulate
  logic                    s1_valid;
  gbad_pkg::cls_t          s1_cls;
  logic [IW-1:0]           s1_idx;
  logic                    lw_valid;
  logic [IW-1:0]           lw_idx;
  logic signed [SUM_W-1:0] lw_sum;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] acc_sum;

  // stage 2: partial products
  logic                          s2_valid;
  logic signed [SUM_W-1:0]       s2_sum;
  logic [gbad_pkg::CELL_W-1:0]   s2_cell;
  logic                          s2_last;
  logic signed [PH_W-1:0]        prod_hi;
  logic [FRAC+SW-1:0]            prod_lo;

  // stage 3: combine and saturate
  logic                          s3_valid;
  logic signed [PH_W-1:0]        s3_hi;
  logic [SW-1:0]                 s3_lo;
  logic [gbad_pkg::CELL_W-1:0]   s3_cell;
  logic                          s3_last;
  logic signed [TW-1:0]          total;

  int unsigned busy;

  // reserve output queue room for every result still in the pipe
  always_comb begin
    busy = 32'(out_count) + 32'(s1_valid && s1_cls.done) + 32'(s2_valid) + 32'(s3_valid);
    mid_pop = !mid_empty && (busy < gbad_pkg::OUT_DEPTH);
  end

  always_ff @(posedge clk) begin
    rd_sum <= acc_mem[mid_idx];
    if (s1_valid) begin
      acc_mem[s1_idx] <= acc_sum;
    end
  end

  // the read for this item missed only the write of the item just before it
  always_comb begin
    if (s1_cls.first) begin
      base = '0;
    end else if (lw_valid && (lw_idx == s1_idx)) begin
      base = lw_sum;
    end else begin
      base = rd_sum;
    end
    acc_sum = base + SUM_W'(s1_cls.sample);
  end

  always_comb begin
    prod_hi = $signed(s2_sum[SUM_W-1:FRAC]) * $signed({1'b0, recip_scale});
    prod_lo = s2_sum[FRAC-1:0] * recip_scale;
  end

  always_comb begin
    total = s3_hi + $signed({1'b0, s3_lo});
    if (total > POS_LIM) begin
      out_res.mean_value = 32'sh7FFF_FFFF;
    end else if (total < NEG_LIM) begin
      out_res.mean_value = 32'sh8000_0000;
    end else begin
      out_res.mean_value = total[gbad_pkg::SAMPLE_W-1:0];
    end
    out_res.cell_index = s3_cell;
    out_res.last       = s3_last;
    out_push           = s3_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= mid_pop;
      lw_valid <= s1_valid;
      s2_valid <= s1_valid && s1_cls.done;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_cls  <= mid_cls;
    s1_idx  <= mid_idx;
    lw_idx  <= s1_idx;
    lw_sum  <= acc_sum;
    s2_sum  <= acc_sum;
    s2_cell <= s1_cls.cell_index;
    s2_last <= s1_cls.last;
    s3_hi   <= prod_hi;
    s3_lo   <= prod_lo[FRAC+SW-1:FRAC];
    s3_cell <= s2_cell;
    s3_last <= s2_last;
  end

endmodule

// File: rtl/core/grid_box_average_downsample.sv
// ----------------------------------------------------------------------------
// grid_box_average_downsample
// 3-D average pooling of a streamed cubic grid with APB configuration.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless stalled; accumulator memory reads
//   every cycle, writes each sample and forwards the previous write to the
//   next sample. Block means pass accumulate, scale and saturate stages.
// Input stalls only when the front queue fills behind unread results.
// Reset (rst, synchronous): registers to M=1, K=1, scale 1.0; position and
//   queues cleared; accumulators are not cleared (block start overwrites).
module grid_box_average_downsample #(
  parameter int MAX_OUT_SIDE = gbad_pkg::DEF_MAX_OUT_SIDE,
  parameter int MAX_BLOCK    = gbad_pkg::DEF_MAX_BLOCK
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [gbad_pkg::ADDR_W-1:0] paddr,
  input  logic [gbad_pkg::DATA_W-1:0] pwdata,
  output logic [gbad_pkg::DATA_W-1:0] prdata,
  output logic pready,
  input  logic push,
  input  logic signed [gbad_pkg::SAMPLE_W-1:0] sample,
  output logic full,
  input  logic pop,
  output logic empty,
  output logic signed [gbad_pkg::SAMPLE_W-1:0] mean_value,
  output logic [gbad_pkg::CELL_W-1:0] cell_index,
  output logic last
);

  localparam int MW    = $clog2(MAX_OUT_SIDE+1);
  localparam int MMW   = $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE+1);
  localparam int KW    = $clog2(MAX_BLOCK+1);
  localparam int IW    = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE*MAX_OUT_SIDE) : 1;
  localparam int CLS_W = $bits(gbad_pkg::cls_t);
  localparam int MID_W = IW + CLS_W;
  localparam int RES_W = $bits(gbad_pkg::res_t);

  logic [gbad_pkg::SIDE_REG_W-1:0]  out_side;
  logic [gbad_pkg::BLOCK_REG_W-1:0] block_size;
  logic [gbad_pkg::SCALE_W-1:0]     recip_scale;
  logic [MW-1:0]  side;
  logic [MMW-1:0] side_sq;
  logic [KW-1:0]  blk;

  gbad_pkg::reg_idx_t reg_idx;
  logic        cfg_wr;
  logic        geo_clear;
  int unsigned side_i;
  int unsigned blk_i;

  logic           accept;
  gbad_pkg::cls_t front_cls;
  logic [IW-1:0]  front_idx;
  logic [MID_W-1:0] mid_dout;
  logic           mid_empty;
  logic           mid_pop;
  logic           out_push;
  gbad_pkg::res_t out_res;
  logic [RES_W-1:0] out_dout;
  gbad_pkg::res_t out_head;
  logic [$clog2(gbad_pkg::OUT_DEPTH+1)-1:0] out_count;

  assign pready  = 1'b1;
  assign reg_idx = gbad_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign geo_clear = cfg_wr && ((reg_idx == gbad_pkg::REG_OUT_SIDE) ||
                                (reg_idx == gbad_pkg::REG_BLOCK_SIZE));

  // clamp the written geometry to the supported range
  always_comb begin
    side_i = 32'(pwdata[gbad_pkg::SIDE_REG_W-1:0]);
    if (side_i == 0) begin
      side_i = 1;
    end else if (side_i > MAX_OUT_SIDE) begin
      side_i = MAX_OUT_SIDE;
    end
    blk_i = 32'(pwdata[gbad_pkg::BLOCK_REG_W-1:0]);
    if (blk_i == 0) begin
      blk_i = 1;
    end else if (blk_i > MAX_BLOCK) begin
      blk_i = MAX_BLOCK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_side    <= gbad_pkg::SIDE_REG_W'(1);
      block_size  <= gbad_pkg::BLOCK_REG_W'(1);
      recip_scale <= gbad_pkg::SCALE_RESET;
      side        <= MW'(1);
      side_sq     <= MMW'(1);
      blk         <= KW'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        gbad_pkg::REG_OUT_SIDE: begin
          out_side <= pwdata[gbad_pkg::SIDE_REG_W-1:0];
          side     <= MW'(side_i);
          side_sq  <= MMW'(side_i * side_i);
        end
        gbad_pkg::REG_BLOCK_SIZE: begin
          block_size <= pwdata[gbad_pkg::BLOCK_REG_W-1:0];
          blk        <= KW'(blk_i);
        end
        gbad_pkg::REG_RECIP_SCALE: begin
          recip_scale <= pwdata[gbad_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gbad_pkg::REG_OUT_SIDE:    prdata = gbad_pkg::DATA_W'(out_side);
      gbad_pkg::REG_BLOCK_SIZE:  prdata = gbad_pkg::DATA_W'(block_size);
      gbad_pkg::REG_RECIP_SCALE: prdata = gbad_pkg::DATA_W'(recip_scale);
      default:                   prdata = '0;
    endcase
  end

  assign accept = push && !full;

  gbad_front #(
    .MAX_OUT_SIDE (MAX_OUT_SIDE),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .clear   (geo_clear),
    .side    (side),
    .side_sq (side_sq),
    .blk     (blk),
    .accept  (accept),
    .sample  (sample),
    .cls     (front_cls),
    .idx     (front_idx)
  );

  gbad_fifo #(
    .WIDTH (MID_W),
    .DEPTH (gbad_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   ({front_idx, front_cls}),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count ()
  );

  gbad_back #(
    .MAX_OUT_SIDE (MAX_OUT_SIDE),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .recip_scale (recip_scale),
    .mid_empty   (mid_empty),
    .mid_cls     (gbad_pkg::cls_t'(mid_dout[CLS_W-1:0])),
    .mid_idx     (mid_dout[MID_W-1:CLS_W]),
    .mid_pop     (mid_pop),
    .out_count   (out_count),
    .out_push    (out_push),
    .out_res     (out_res)
  );

  gbad_fifo #(
    .WIDTH (RES_W),
    .DEPTH (gbad_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_res),
    .full  (),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty),
    .count (out_count)
  );

  assign out_head   = gbad_pkg::res_t'(out_dout);
  assign mean_value = out_head.mean_value;
  assign cell_index = out_head.cell_index;
  assign last       = out_head.last;

endmodule

// File: rtl/core/gbad_checker.sv
// ----------------------------------------------------------------------------
// gbad_checker
// Port-level checks for the grid box average downsampler, bound to the top.
// ----------------------------------------------------------------------------
module gbad_checker (
  input logic clk,
  input logic rst,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic [gbad_pkg::ADDR_W-1:0] paddr,
  input logic [gbad_pkg::DATA_W-1:0] pwdata,
  input logic [gbad_pkg::DATA_W-1:0] prdata,
  input logic pready,
  input logic full,
  input logic empty
);

  logic scale_sel;
  logic scale_wr;
  assign scale_sel = (paddr[3:2] == gbad_pkg::REG_RECIP_SCALE);
  assign scale_wr  = psel && penable && pwrite && pready && scale_sel;

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // the pipe is several stages deep, so no result can follow reset at once
  a_reset_empty: assert property (@(posedge clk) rst |=> empty ##1 empty ##1 empty)
    else $error("result appeared too soon after reset");

  a_scale_readback: assert property (@(posedge clk) disable iff (rst)
      (scale_wr ##1 scale_sel) |->
      (prdata == gbad_pkg::DATA_W'($past(pwdata[gbad_pkg::SCALE_W-1:0]))))
    else $error("recip_scale readback mismatch");

endmodule

bind grid_box_average_downsample gbad_checker u_gbad_checker (.*);
